// File: rtl/mts_pkg.sv
`timescale 1ns / 1ps
package mts_pkg;

	localparam int MAX_BINS   = 1024;
	localparam int ADDR_W     = $clog2(MAX_BINS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int KIND_W     = 2;
	localparam int BIN_W      = 10;
	localparam int VAL_W      = 16;
	localparam int THR_W      = 21;
	localparam int NBINS_W    = 11;
	localparam int SMR_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CMP_W      = (CNT_W > NBINS_W) ? CNT_W : NBINS_W;

	localparam int ATT_LIMIT  = 960;
	localparam int ATT_W      = 21;
	localparam int ROM_IDX_W  = $clog2(ATT_LIMIT + 1);
	localparam int GAIN_W     = 17;
	localparam int SQ_W       = 2 * VAL_W;
	localparam int PROD_W     = GAIN_W + SQ_W;
	localparam int ENERGY_W   = PROD_W + ADDR_W;
	localparam int ROOT_W     = (ENERGY_W + 1) / 2;
	localparam int IT_W       = $clog2(ROOT_W + 1);
	localparam int SCL_W      = ROOT_W + SMR_W;
	localparam int SCL_SHIFT  = 24;
	localparam int MOD_STEPS  = 6;
	localparam int MOD_W      = BIN_W + MOD_STEPS + 2;

	localparam logic [THR_W-1:0]   THR_MAX     = {THR_W{1'b1}};
	localparam logic [NBINS_W-1:0] BINS_RESET  = 11'd1024;
	localparam logic [SMR_W-1:0]   SMR_RESET   = 16'd1163;
	localparam logic [63:0]        STEP_Q63    = 64'd9091587583161718947;

	localparam logic [KIND_W-1:0] KIND_BARK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MAG   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BINS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SMR  = 1'b1;

	typedef struct packed {
		logic [NBINS_W-1:0] bins_in_use;
		logic [SMR_W-1:0]   inverse_smr;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] slot;
		logic [BIN_W-1:0]  bin;
		logic [VAL_W-1:0]  value;
	} item_t;

	typedef struct packed {
		logic [1:0] fill;
	} front_stat_t;

	typedef logic [GAIN_W-1:0] gain_rom_t [ATT_LIMIT+1];

	// Gain table: successive powers of 10^(-1/160) kept in Q1.63, rounded to Q1.16.
	function automatic gain_rom_t build_gain_rom();
		gain_rom_t    rom;
		logic [63:0]  acc;
		logic [127:0] p;
		acc = 64'h8000_0000_0000_0000;
		for (int i = 0; i <= ATT_LIMIT; i++) begin
			rom[i] = GAIN_W'((acc + 64'h0000_4000_0000_0000) >> 47);
			p = {64'd0, acc} * {64'd0, STEP_Q63};
			acc = p[126:63];
		end
		return rom;
	endfunction

	localparam gain_rom_t GAIN_ROM = build_gain_rom();

	// Remainder by the store depth through a short chain of compare-subtract steps.
	function automatic logic [ADDR_W-1:0] bin_slot(input logic [BIN_W-1:0] bin);
		logic [MOD_W-1:0] r;
		logic [MOD_W-1:0] m;
		r = MOD_W'(bin);
		for (int s = MOD_STEPS - 1; s >= 0; s--) begin
			m = MOD_W'(MAX_BINS) << s;
			if (r >= m)
				r = r - m;
		end
		return ADDR_W'(r);
	endfunction

endpackage

// File: rtl/mts_if.sv
`timescale 1ns / 1ps
interface mts_in_if;
	import mts_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BIN_W-1:0]  bin_index;
	logic [VAL_W-1:0]  value;
	modport source (output valid, kind, bin_index, value, input ready);
	modport sink (input valid, kind, bin_index, value, output ready);
endinterface

interface mts_out_if;
	import mts_pkg::*;
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] result_bin;
	logic [THR_W-1:0] threshold;
	modport source (output valid, result_bin, threshold, input ready);
	modport sink (input valid, result_bin, threshold, output ready);
endinterface

// File: rtl/masking_threshold_spreader_unit.sv
`timescale 1ns / 1ps
// Loads are written into their store when the engine pops them. A query walks
// bins_in_use entries (capped at 1024) through one read port per store, drains the
// multiply-accumulate pipeline, runs a one-bit-a-step square root, then scales.
// A two-beat queue in front takes input while the engine works. Reset clears control
// and configuration (bins_in_use 1024, inverse_smr 1163); the stores keep no reset.
module masking_threshold_spreader_unit import mts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mts_in_if.sink                in_ch,
	mts_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t        cfg_q;
	item_t       head;
	logic        head_valid;
	logic        pop;
	front_stat_t front_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bins_in_use <= BINS_RESET;
			cfg_q.inverse_smr <= SMR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BINS: cfg_q.bins_in_use <= NBINS_W'(cfg_wdata);
				REG_SMR:  cfg_q.inverse_smr <= SMR_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	mts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.stat       (front_stat)
	);

	mts_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cfg        (cfg_q),
		.out_ch     (out_ch)
	);

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.threshold))
		else $error("result changed while stalled");

	a_ready_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (front_stat.fill != 2'd2))
		else $error("input ready does not follow queue fill");

	a_smr_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_SMR |=> cfg_q.inverse_smr == $past(cfg_wdata))
		else $error("inverse_smr write lost");
`endif

endmodule

// File: rtl/mts_front.sv
`timescale 1ns / 1ps
module mts_front import mts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mts_in_if.sink      in_ch,
	output item_t       head,
	output logic        head_valid,
	input  logic        pop,
	output front_stat_t stat
);

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	item_t      item;

	assign in_ch.ready = (fill_q != 2'd2);

	// Unknown kinds are taken and dropped here.
	assign push = in_ch.valid && in_ch.ready && (in_ch.kind != KIND_NONE);

	assign item.kind  = in_ch.kind;
	assign item.slot  = bin_slot(in_ch.bin_index);
	assign item.bin   = in_ch.bin_index;
	assign item.value = in_ch.value;

	assign head       = fifo_q[rd_ptr_q];
	assign head_valid = (fill_q != 2'd0);
	assign stat.fill  = fill_q;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule

// File: rtl/mts_engine.sv
`timescale 1ns / 1ps
module mts_engine import mts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t head,
	input  logic  head_valid,
	output logic  pop,
	input  cfg_t  cfg,
	mts_out_if.source out_ch
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_TGT   = 8'b0000_0010,
		ST_TGW   = 8'b0000_0100,
		ST_WALK  = 8'b0000_1000,
		ST_DRAIN = 8'b0001_0000,
		ST_ROOT  = 8'b0010_0000,
		ST_SCALE = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [VAL_W-1:0] bark_mem [MAX_BINS];
	logic [VAL_W-1:0] mag_mem [MAX_BINS];
	logic [VAL_W-1:0] bark_rd_q;
	logic [VAL_W-1:0] mag_rd_q;
	logic [ADDR_W-1:0] rd_addr;

	logic [ADDR_W-1:0] k_q;
	logic [BIN_W-1:0]  bin_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  j_next;
	logic [CNT_W-1:0]  n_sel;
	logic [VAL_W-1:0]  tgt_q;
	logic              issue;

	logic              above;
	logic [VAL_W-1:0]  diff;
	logic [ATT_W-1:0]  att;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [ROM_IDX_W-1:0] idx_s2;
	logic                 over_s2;
	logic [SQ_W-1:0]      sq_s2;
	logic [GAIN_W-1:0]    gain_s3;
	logic [SQ_W-1:0]      sq_s3;
	logic [PROD_W-1:0]    prod_s4;
	logic [ENERGY_W-1:0]  energy_q;

	logic [2*ROOT_W-1:0] x_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [IT_W-1:0]     it_q;
	logic [ROOT_W+1:0]   shifted;
	logic [ROOT_W+1:0]   trial;
	logic                take;

	logic [SCL_W-1:0]           scl_q;
	logic [SCL_W-SCL_SHIFT-1:0] scl_hi;
	logic [THR_W-1:0]           thr;
	logic                       out_load;
	logic                       out_valid_q;
	logic [BIN_W-1:0]           out_bin_q;
	logic [THR_W-1:0]           out_thr_q;

	assign pop = (state_q == ST_IDLE) && head_valid;

	assign n_sel = (CMP_W'(cfg.bins_in_use) > CMP_W'(MAX_BINS)) ? CNT_W'(MAX_BINS)
	                                                              : CNT_W'(cfg.bins_in_use);

	assign rd_addr = (state_q == ST_TGT) ? k_q : j_q[ADDR_W-1:0];
	assign issue   = (state_q == ST_WALK);
	assign j_next  = j_q + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (pop && head.kind == KIND_BARK)
			bark_mem[head.slot] <= head.value;
		bark_rd_q <= bark_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == KIND_MAG)
			mag_mem[head.slot] <= head.value;
		mag_rd_q <= mag_mem[rd_addr];
	end

	// Steeper slope when the target lies below the masker.
	assign above = bark_rd_q > tgt_q;
	assign diff  = above ? (bark_rd_q - tgt_q) : (tgt_q - bark_rd_q);
	assign att   = above ? ((ATT_W'(diff) * ATT_W'(25)) >> 5)
	                     : ((ATT_W'(diff) * ATT_W'(5)) >> 4);

	always_ff @(posedge clk) begin
		idx_s2  <= ROM_IDX_W'(att);
		over_s2 <= (att > ATT_W'(ATT_LIMIT));
		sq_s2   <= SQ_W'(mag_rd_q) * SQ_W'(mag_rd_q);
		gain_s3 <= over_s2 ? GAIN_W'(0) : GAIN_ROM[idx_s2];
		sq_s3   <= sq_s2;
		prod_s4 <= PROD_W'(gain_s3) * PROD_W'(sq_s3);
	end

	assign shifted = {rem_q[ROOT_W-1:0], x_q[2*ROOT_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign take    = shifted >= trial;

	assign scl_hi = scl_q[SCL_W-1:SCL_SHIFT];
	assign thr    = ((SCL_W-SCL_SHIFT)'(THR_MAX) < scl_hi) ? THR_MAX : THR_W'(scl_hi);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			k_q   <= head.slot;
			bin_q <= head.bin;
			n_q   <= n_sel;
		end
		if (state_q == ST_TGT) begin
			energy_q <= '0;
			j_q      <= '0;
		end else begin
			if (issue)
				j_q <= j_next;
			if (v_s4)
				energy_q <= energy_q + ENERGY_W'(prod_s4);
		end
		if (state_q == ST_TGW)
			tgt_q <= bark_rd_q;
		if (state_q == ST_DRAIN) begin
			x_q    <= (2*ROOT_W)'(energy_q);
			rem_q  <= '0;
			root_q <= '0;
			it_q   <= IT_W'(ROOT_W);
		end else if (state_q == ST_ROOT) begin
			x_q    <= x_q << 2;
			rem_q  <= take ? (shifted - trial) : shifted;
			root_q <= {root_q[ROOT_W-2:0], take};
			it_q   <= it_q - IT_W'(1);
		end
		if (state_q == ST_SCALE)
			scl_q <= SCL_W'(root_q) * SCL_W'(cfg.inverse_smr);
		if (out_load) begin
			out_bin_q <= bin_q;
			out_thr_q <= thr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.kind == KIND_QUERY)
						state_q <= ST_TGT;
				end
				ST_TGT: state_q <= ST_TGW;
				ST_TGW: state_q <= (n_q == '0) ? ST_DRAIN : ST_WALK;
				ST_WALK: begin
					if (j_next == n_q)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4))
						state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (it_q == IT_W'(1))
						state_q <= ST_SCALE;
				end
				ST_SCALE: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.result_bin = out_bin_q;
	assign out_ch.threshold  = out_thr_q;

endmodule
